// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, held off while rst_ni is low
`define MVT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// concurrent check on clk_i that also runs through reset
`define MVT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/mvt_pkg.sv =====
// shared widths, types and constants of the 4x4 vertex transform
package mvt_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  // four products of 2*DATA_W bits summed exactly
  localparam int ACC_W         = PROD_W + 2;
  // one more bit for the rounding offset
  localparam int RND_W         = ACC_W + 1;
  localparam int NUM_ROWS      = 4;
  localparam int NUM_COLS      = 4;
  localparam int CFG_NUM       = 8;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = $clog2(CFG_NUM);
  localparam int CFG_IDX_LSB   = 3;
  localparam int CFG_AW        = CFG_IDX_W + CFG_IDX_LSB;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [NUM_ROWS-1:0]     vec_t;
  typedef vec_t [NUM_COLS-1:0]      mat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t [NUM_ROWS-1:0]     prod_vec_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef acc_t [NUM_ROWS-1:0]      acc_vec_t;
  typedef logic [CFG_W-1:0]         cfg_t;

  // identity matrix at 16 fraction bits
  localparam cfg_t CFG_RESET [CFG_NUM] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  localparam word_t SAT_MAX = 32'sh7FFF_FFFF;
  localparam word_t SAT_MIN = 32'sh8000_0000;

endpackage

// ===== rtl/mvt_regs.sv =====
// apb register file holding the column-major matrix
module mvt_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvt_pkg::CFG_AW-1:0]   paddr,
  input  logic [mvt_pkg::CFG_W-1:0]    pwdata,
  output logic [mvt_pkg::CFG_W-1:0]    prdata,
  output logic                         pready,
  output mvt_pkg::mat_t                mat_o
);
  import mvt_pkg::*;

  cfg_t                 reg_q [CFG_NUM];
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_AW-1:CFG_IDX_LSB];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q <= CFG_RESET;
    end else if (wr_en) begin
      reg_q[idx] <= pwdata;
    end
  end

  // read back
  assign prdata = reg_q[idx];

  // split each register into two entries of its column
  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        mat_o[c][r] = reg_q[2 * c + r / 2][(r % 2) * DATA_W +: DATA_W];
      end
    end
  end

endmodule

// ===== rtl/mvt_cell.sv =====
// one column cell: multiply stage, then accumulate stage
module mvt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mvt_pkg::vec_t       col_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mvt_pkg::vec_t       vec_i,
  input  mvt_pkg::acc_vec_t   psum_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mvt_pkg::vec_t       vec_o,
  output mvt_pkg::acc_vec_t   psum_o
);
  import mvt_pkg::*;

  logic      a_valid_q, b_valid_q;
  logic      a_en, b_en;
  vec_t      a_vec_q, b_vec_q;
  prod_vec_t a_prod_q;
  acc_vec_t  a_psum_q, b_psum_q;

  // stage enables, a bubble is filled even while downstream stalls
  assign b_en       = !b_valid_q || !out_stall_i;
  assign a_en       = !a_valid_q || b_en;
  assign in_stall_o = !a_en;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_q <= in_valid_i;
      end
      if (b_en) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // multiply stage: this column times the leading component
  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_vec_q  <= vec_i;
      a_psum_q <= psum_i;
      for (int r = 0; r < NUM_ROWS; r++) begin
        a_prod_q[r] <= prod_t'($signed(col_i[r])) * prod_t'($signed(vec_i[0]));
      end
    end
  end

  // accumulate stage, component list moves down by one
  always_ff @(posedge clk_i) begin
    if (b_en) begin
      b_vec_q <= {word_t'(0), a_vec_q[NUM_ROWS-1:1]};
      for (int r = 0; r < NUM_ROWS; r++) begin
        b_psum_q[r] <= $signed(a_psum_q[r]) + acc_t'($signed(a_prod_q[r]));
      end
    end
  end

  assign out_valid_o = b_valid_q;
  assign vec_o       = b_vec_q;
  assign psum_o      = b_psum_q;

endmodule

// ===== rtl/mvt_round.sv =====
// round half up, saturate and hold the result word
module mvt_round #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mvt_pkg::acc_vec_t   psum_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mvt_pkg::vec_t       vout_o,
  output logic                clipped_o
);
  import mvt_pkg::*;

  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (FRAC_BITS - 1);

  logic                    valid_q;
  logic                    en;
  vec_t                    vout_q, vout_d;
  logic                    clip_q, clip_d;
  logic signed [RND_W-1:0] rnd_s [NUM_ROWS];
  logic signed [RND_W-1:0] shr_s [NUM_ROWS];

  assign en         = !valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // add half, shift down, clamp to the word range
  always_comb begin
    clip_d = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      rnd_s[r] = RND_W'($signed(psum_i[r])) + HALF;
      shr_s[r] = rnd_s[r] >>> FRAC_BITS;
      if ((&shr_s[r][RND_W-1:DATA_W-1]) || !(|shr_s[r][RND_W-1:DATA_W-1])) begin
        vout_d[r] = shr_s[r][DATA_W-1:0];
      end else begin
        vout_d[r] = shr_s[r][RND_W-1] ? SAT_MIN : SAT_MAX;
        clip_d    = 1'b1;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (en) begin
      vout_q <= vout_d;
      clip_q <= clip_d;
    end
  end

  assign out_valid_o = valid_q;
  assign vout_o      = vout_q;
  assign clipped_o   = clip_q;

endmodule

// ===== rtl/mat4_vec4_transform.sv =====
// an accepted input word passes through a chain of four column cells,
//   each one multiply stage and one accumulate stage, then a round stage
// throughput: one vector per cycle while out_stall_i is low
// stalls collapse bubbles stage by stage; input is taken while bubbles remain
// reset clears all valid bits and loads the identity matrix (16 fraction bits)
module mat4_vec4_transform #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvt_pkg::CFG_AW-1:0]   paddr,
  input  logic [mvt_pkg::CFG_W-1:0]    pwdata,
  output logic [mvt_pkg::CFG_W-1:0]    prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [mvt_pkg::DATA_W-1:0] vin_x_i,
  input  logic signed [mvt_pkg::DATA_W-1:0] vin_y_i,
  input  logic signed [mvt_pkg::DATA_W-1:0] vin_z_i,
  input  logic signed [mvt_pkg::DATA_W-1:0] vin_w_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [mvt_pkg::DATA_W-1:0] vout_x_o,
  output logic signed [mvt_pkg::DATA_W-1:0] vout_y_o,
  output logic signed [mvt_pkg::DATA_W-1:0] vout_z_o,
  output logic signed [mvt_pkg::DATA_W-1:0] vout_w_o,
  output logic                         clipped_o
);
  import mvt_pkg::*;

  mat_t     mat;
  logic     valid_s [NUM_COLS+1];
  logic     stall_s [NUM_COLS+1];
  vec_t     vec_s   [NUM_COLS+1];
  acc_vec_t psum_s  [NUM_COLS+1];
  vec_t     vout;

  // matrix registers
  mvt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mat_o   (mat)
  );

  // head of the chain
  assign valid_s[0]  = in_valid_i;
  assign in_stall_o  = stall_s[0];
  assign vec_s[0]    = {vin_w_i, vin_z_i, vin_y_i, vin_x_i};
  assign psum_s[0]   = '0;

  // one cell per matrix column
  for (genvar c = 0; c < NUM_COLS; c++) begin : g_cell
    mvt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .col_i       (mat[c]),
      .in_valid_i  (valid_s[c]),
      .in_stall_o  (stall_s[c]),
      .vec_i       (vec_s[c]),
      .psum_i      (psum_s[c]),
      .out_valid_o (valid_s[c+1]),
      .out_stall_i (stall_s[c+1]),
      .vec_o       (vec_s[c+1]),
      .psum_o      (psum_s[c+1])
    );
  end

  // rounding and output register
  mvt_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_s[NUM_COLS]),
    .in_stall_o  (stall_s[NUM_COLS]),
    .psum_i      (psum_s[NUM_COLS]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .vout_o      (vout),
    .clipped_o   (clipped_o)
  );

  assign vout_x_o = vout[0];
  assign vout_y_o = vout[1];
  assign vout_z_o = vout[2];
  assign vout_w_o = vout[3];

endmodule

// ===== rtl/mvt_checker.sv =====
// port-level checks on the vertex transform, bound to the top level
`include "assert_macros.svh"

module mvt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [mvt_pkg::CFG_AW-1:0]   paddr,
  input logic [mvt_pkg::CFG_W-1:0]    pwdata,
  input logic [mvt_pkg::CFG_W-1:0]    prdata,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [mvt_pkg::DATA_W-1:0] vout_x_o,
  input logic signed [mvt_pkg::DATA_W-1:0] vout_y_o,
  input logic signed [mvt_pkg::DATA_W-1:0] vout_z_o,
  input logic signed [mvt_pkg::DATA_W-1:0] vout_w_o,
  input logic                         clipped_o
);
  import mvt_pkg::*;

  // a stalled word stays offered
  `MVT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result word dropped")

  // a stalled word keeps its payload
  `MVT_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(vout_x_o) && $stable(vout_y_o) && $stable(vout_z_o) && $stable(vout_w_o) && $stable(clipped_o), "stalled result changed")

  // a clipped word carries at least one saturated component
  `MVT_ASSERT(a_clip_sat, out_valid_o && clipped_o |-> vout_x_o == SAT_MAX || vout_x_o == SAT_MIN || vout_y_o == SAT_MAX || vout_y_o == SAT_MIN || vout_z_o == SAT_MAX || vout_z_o == SAT_MIN || vout_w_o == SAT_MAX || vout_w_o == SAT_MIN, "clipped without saturation")

  // a register reads back what was just written there
  `MVT_ASSERT_ALWAYS(a_cfg_readback, rst_ni && $past(rst_ni) && $past(psel && penable && pwrite) && psel && !pwrite && paddr == $past(paddr) |-> prdata == $past(pwdata), "register readback mismatch")

endmodule

bind mat4_vec4_transform mvt_checker u_mvt_checker (.*);

// ===== dv/tb_mat4_vec4_transform.sv =====
// testbench for the 4x4 fixed-point vertex transform: directed and random vectors
`timescale 1ns / 100ps

module tb_mat4_vec4_transform;
  import mvt_pkg::*;

  localparam int FRAC_BITS   = FRAC_BITS_DEF;
  localparam int SETTLE_CYC  = 16;
  localparam int LONG_HOLD   = 120;
  localparam int MAX_REPORTS = 40;
  localparam logic signed [127:0] POS_LIM = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] NEG_LIM = -128'sh8000_0000;

  // matrix register indexes
  typedef enum int {
    COL0_ROWS01, COL0_ROWS23, COL1_ROWS01, COL1_ROWS23,
    COL2_ROWS01, COL2_ROWS23, COL3_ROWS01, COL3_ROWS23
  } mat_reg_e;

  // one transformed vertex: components x..w then the saturation flag
  typedef struct packed {
    vec_t comp;
    logic clip;
  } vertex_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_W-1:0]    pwdata;
  logic [CFG_W-1:0]    prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  word_t               vin_x_i, vin_y_i, vin_z_i, vin_w_i;
  logic                out_valid_o;
  logic                out_stall_i;
  word_t               vout_x_o, vout_y_o, vout_z_o, vout_w_o;
  logic                clipped_o;

  // shadow of the matrix registers and the vertices still owed by the block
  cfg_t    mat_shadow [CFG_NUM];
  vertex_t pending_vertices [$];

  int err_cnt;
  int n_vectors;
  int n_results;
  int n_clipped;
  int n_loads;
  int n_readbacks;
  int burst_left;
  bit steady_sender;
  bit long_hold_req;

  string comp_name [NUM_ROWS] = '{"x", "y", "z", "w"};

  mat4_vec4_transform #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .vin_x_i    (vin_x_i),
    .vin_y_i    (vin_y_i),
    .vin_z_i    (vin_z_i),
    .vin_w_i    (vin_w_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .vout_x_o   (vout_x_o),
    .vout_y_o   (vout_y_o),
    .vout_z_o   (vout_z_o),
    .vout_w_o   (vout_w_o),
    .clipped_o  (clipped_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // exact sum of products, round half up, saturate to 32 bits
  function automatic vertex_t transform_vertex(vec_t v);
    vertex_t             r;
    logic signed [127:0] acc;
    word_t               m;
    word_t               c;
    cfg_t                pair;
    r.clip = 1'b0;
    for (int row = 0; row < NUM_ROWS; row++) begin
      acc = '0;
      for (int col = 0; col < NUM_COLS; col++) begin
        pair = mat_shadow[col * 2 + row / 2];
        m = row[0] ? pair[63:32] : pair[31:0];
        c = v[col];
        acc = acc + m * c;
      end
      acc = acc + (128'sd1 <<< (FRAC_BITS - 1));
      acc = acc >>> FRAC_BITS;
      if (acc > POS_LIM) begin
        r.comp[row] = SAT_MAX;
        r.clip = 1'b1;
      end else if (acc < NEG_LIM) begin
        r.comp[row] = SAT_MIN;
        r.clip = 1'b1;
      end else begin
        r.comp[row] = acc[31:0];
      end
    end
    return r;
  endfunction

  function automatic vec_t mk_vec(word_t x, word_t y, word_t z, word_t w);
    vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    return v;
  endfunction

  // vector component: full range, small values, extremes or near a rounding half
  function automatic word_t rand_component();
    word_t pick [6] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1,
                        32'sh1_0000, 32'sh8000};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      7:          return pick[$urandom_range(0, 5)];
      default:    return {4'($urandom_range(0, 15) - 8), 12'h0, 4'h8,
                          12'($urandom_range(0, 4095))};
    endcase
  endfunction

  // matrix register pair: full range, small entries or extreme entries
  function automatic cfg_t rand_cfg(int kind);
    word_t pick [5] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1, 32'sh1_0000};
    case (kind)
      0:       return {$urandom, $urandom};
      1:       return {$signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000,
                       $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000};
      default: return {pick[$urandom_range(0, 4)], pick[$urandom_range(0, 4)]};
    endcase
  endfunction

  // offer one vector in the sender's burst pattern, return once it is taken
  task automatic offer_vertex(vec_t v);
    int  gap;
    bit  taken;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    vin_x_i    <= v[0];
    vin_y_i    <= v[1];
    vin_z_i    <= v[2];
    vin_w_i    <= v[3];
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    pending_vertices.push_back(transform_vertex(v));
    n_vectors++;
  endtask

  // stop sending and wait until every owed vertex has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // register write: setup cycle, then access until pready
  task automatic cfg_write(mat_reg_e idx, cfg_t val);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(int'(idx) << CFG_IDX_LSB);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    mat_shadow[idx] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // register read, compared with the shadow copy
  task automatic cfg_check(mat_reg_e idx);
    bit   rdy;
    cfg_t got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_AW'(int'(idx) << CFG_IDX_LSB);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      got = prdata;
      @(posedge clk_i);
    end while (!rdy);
    n_readbacks++;
    if (got !== mat_shadow[idx]) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: register %s readback mismatch: expected %h, got %h",
                 $time, idx.name(), mat_shadow[idx], got);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // load a whole matrix while idle and read it back
  task automatic load_matrix(cfg_t vals [CFG_NUM]);
    wait_idle();
    for (int i = 0; i < CFG_NUM; i++) cfg_write(mat_reg_e'(i), vals[i]);
    for (int i = 0; i < CFG_NUM; i++) cfg_check(mat_reg_e'(i));
    n_loads++;
  endtask

  task automatic fill_matrix(word_t e);
    cfg_t vals [CFG_NUM];
    foreach (vals[i]) vals[i] = {e, e};
    load_matrix(vals);
  endtask

  // reset values read back, identity passes extremes through unclipped
  task automatic test_reset_state();
    mat_shadow = CFG_RESET;
    for (int i = 0; i < CFG_NUM; i++) cfg_check(mat_reg_e'(i));
    offer_vertex(mk_vec(32'sh0, 32'sh0, 32'sh0, 32'sh0));
    offer_vertex(mk_vec(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1, -32'sh1));
    offer_vertex(mk_vec(32'sh1234_5678, -32'sh0765_4321, 32'sh8000, 32'sh7FFF));
    offer_vertex(mk_vec(-32'sh1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0));
  endtask

  // positive and negative overflow, rounding halves, edges of the range
  task automatic test_saturation_and_rounding();
    fill_matrix(32'sh7FFF_FFFF);
    offer_vertex(mk_vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    offer_vertex(mk_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    offer_vertex(mk_vec(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0));
    // largest magnitude sum: four products of the most negative entries
    fill_matrix(32'sh8000_0000);
    offer_vertex(mk_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    offer_vertex(mk_vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    // one lsb entries: output is the sum scaled down, halves round up
    fill_matrix(32'sh1);
    offer_vertex(mk_vec(32'sh8000, 32'sh0, 32'sh0, 32'sh0));
    offer_vertex(mk_vec(32'sh7FFF, 32'sh0, 32'sh0, 32'sh0));
    offer_vertex(mk_vec(-32'sh8000, 32'sh0, 32'sh0, 32'sh0));
    offer_vertex(mk_vec(-32'sh8001, 32'sh0, 32'sh0, 32'sh0));
    // unit entries: just at and just past the saturation limits
    fill_matrix(32'sh1_0000);
    offer_vertex(mk_vec(32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0));
    offer_vertex(mk_vec(32'sh7FFF_FFFF, 32'sh1, 32'sh0, 32'sh0));
    offer_vertex(mk_vec(32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0));
    offer_vertex(mk_vec(32'sh8000_0000, -32'sh1, 32'sh0, 32'sh0));
  endtask

  // several random matrices, each with a stream of random vectors
  task automatic test_random_matrices(int phases, int per_phase);
    cfg_t vals [CFG_NUM];
    vec_t v;
    for (int p = 0; p < phases; p++) begin
      foreach (vals[i]) vals[i] = rand_cfg((p + i) % 3 == 0 ? 2 : p % 2);
      load_matrix(vals);
      steady_sender = (p % 3 == 0);
      for (int n = 0; n < per_phase; n++) begin
        for (int c = 0; c < NUM_COLS; c++) v[c] = rand_component();
        offer_vertex(v);
      end
    end
    steady_sender = 1'b0;
  endtask

  // receiver holds off for a long stretch while vectors keep coming
  task automatic test_backpressure();
    vec_t v;
    steady_sender = 1'b1;
    long_hold_req = 1'b1;
    for (int n = 0; n < 80; n++) begin
      for (int c = 0; c < NUM_COLS; c++) v[c] = rand_component();
      offer_vertex(v);
    end
    steady_sender = 1'b0;
    while (long_hold_req) @(posedge clk_i);
    wait_idle();
  endtask

  // receiver stall pattern, changing mode now and then
  initial begin
    int mode;
    int left;
    int tick;
    out_stall_i = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(30, 200);
        end
        left--;
        tick++;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // result checker: each word leaving the block against the oldest expected vertex
  initial begin
    vertex_t got;
    vertex_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.comp[0] = vout_x_o;
        got.comp[1] = vout_y_o;
        got.comp[2] = vout_z_o;
        got.comp[3] = vout_w_o;
        got.clip    = clipped_o;
        if (pending_vertices.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result word: expected none, got %h", $time, got);
        end else begin
          want = pending_vertices.pop_front();
          n_results++;
          if (want.clip) n_clipped++;
          for (int c = 0; c < NUM_ROWS; c++) begin
            if (got.comp[c] !== want.comp[c]) begin
              err_cnt++;
              if (err_cnt <= MAX_REPORTS)
                $display("%0t: vout_%s mismatch: expected %h, got %h",
                         $time, comp_name[c], want.comp[c], got.comp[c]);
            end
          end
          if (got.clip !== want.clip) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: clipped mismatch: expected %b, got %b",
                       $time, want.clip, got.clip);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // test sequence
  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    vin_x_i       = '0;
    vin_y_i       = '0;
    vin_z_i       = '0;
    vin_w_i       = '0;
    err_cnt       = 0;
    n_vectors     = 0;
    n_results     = 0;
    n_clipped     = 0;
    n_loads       = 0;
    n_readbacks   = 0;
    burst_left    = 0;
    steady_sender = 1'b0;
    long_hold_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_saturation_and_rounding();
    test_random_matrices(8, 220);
    test_backpressure();
    test_random_matrices(1, 60);

    wait_idle();
    $display("summary: %0d vectors, %0d results (%0d saturated), %0d matrix loads",
             n_vectors, n_results, n_clipped, n_loads);
    $display("summary: %0d register readbacks, long receiver hold and drain pauses run",
             n_readbacks);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
